>>> design/rss_pkg.sv
// rss_pkg: shared types and constants of the roulette / rank parent selector
// depends on nothing; used by every module in design/
package rss_pkg;

   localparam int FIT_W  = 24;  // q16.8 fitness width
   localparam int FRAC_W = 24;  // random fraction scale bits
   localparam int IDX_W  = 8;   // entry index / selected index width
   localparam int N_W    = 9;   // population count, 1..256
   localparam int TOT_W  = 32;  // sum of up to 256 fitness entries
   localparam int PROD_W = FRAC_W + TOT_W;

   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_ROULETTE = 2'd1;
   localparam logic [1:0] OP_RANK     = 2'd2;

   typedef struct packed {
      logic [1:0]        operation;
      logic [IDX_W-1:0]  entry_index;
      logic [FIT_W-1:0]  fitness_value;
      logic [FRAC_W-1:0] random_fraction;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] selected_index;
      logic             no_fitness;
   } rsp_type;

   // table write port bundle
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [FIT_W-1:0] data;
   } tbl_wr_type;

endpackage

>>> design/rss_table.sv
// rss_table: fitness table memory with per-entry valid bits cleared at reset
// depends on rss_pkg
module rss_table #(
   parameter int DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rss_pkg::tbl_wr_type       wr,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [rss_pkg::FIT_W-1:0] rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [rss_pkg::FIT_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]          valid_ff;
   logic [DEPTH-1:0]          valid_in;
   logic [rss_pkg::FIT_W-1:0] rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr[AW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rss_mul.sv
// rss_mul: shared registered multiplier, fraction times total or n times (n + 1)
// depends on rss_pkg
module rss_mul (
   input  logic                       clock,
   input  logic [rss_pkg::FRAC_W-1:0] a,
   input  logic [rss_pkg::TOT_W-1:0]  b,
   output logic [rss_pkg::PROD_W-1:0] p
);

   logic [rss_pkg::PROD_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= rss_pkg::PROD_W'(a) * rss_pkg::PROD_W'(b);
   end

   assign p = p_ff;

endmodule

>>> design/roulette_and_rank_selection.sv
// roulette_and_rank_selection: top level, sequencer around one adder/compare
// depends on rss_pkg, rss_table, rss_mul
//  - req channel (req_valid / req_stall / req_data): one beat per item; a load
//    writes one fitness entry, a roulette or rank beat asks for a parent
//  - rsp channel (rsp_valid / rsp_stall / rsp_data) returns one beat per select
//  - csr channel (csr_valid / csr_ready / csr_data) writes pop_size; always ready
// steps, n = active population, from the accepting edge to rsp_valid
//  - a load gives no beat; operation 3 is dropped
//  - roulette: sum the table with a registered read of each entry, a multiplier
//    pass for fraction * total, a second walk of the table until the running
//    sum exceeds the threshold or reaches entry n - 1, then the output register;
//    a zero total skips the walk; req_stall drops as the result is registered
//  - rank: two multiplier passes (n * (n + 1) halved, then fraction * total),
//    running-weight adds under the same stop rule, then the output register
//  - the table's single read port and the one running-sum adder make the sum
//    and walks go entry by entry; req_stall is high for the whole of a select
// reset: synchronous, active high; every table entry reads as zero, pop_size 256
// back pressure: an untaken result holds the output register while rsp_stall is
//    high; a select that finishes meanwhile waits in its last state, req_stall high
module roulette_and_rank_selection #(
   parameter int POP_MAX = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rss_pkg::req_type        req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rss_pkg::rsp_type        rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [rss_pkg::N_W-1:0] csr_data
);

   localparam int DEPTH = (POP_MAX < 256) ? POP_MAX : 256;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = rss_pkg::N_W;
   localparam int TW    = rss_pkg::TOT_W;
   localparam int FR    = rss_pkg::FRAC_W;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SUM   = 3'd1;
   localparam logic [2:0] S_RTOT  = 3'd2;
   localparam logic [2:0] S_RHALF = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_THR   = 3'd5;
   localparam logic [2:0] S_WALK  = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [2:0]                  state_ff, state_in;
   logic [NW-1:0]               pop_ff, pop_in;
   logic [NW-1:0]               n_ff, n_in;
   logic                        rank_ff, rank_in;
   logic [FR-1:0]               rnd_ff, rnd_in;
   logic [TW-1:0]               tot_ff, tot_in;
   logic [TW-1:0]               thr_ff, thr_in;
   logic [TW-1:0]               run_ff, run_in;
   logic [NW-1:0]               iss_ff, iss_in;    // read issue / rank position
   logic [NW-1:0]               pidx_ff, pidx_in;  // index of data coming back
   logic                        vld_ff, vld_in;    // table read data valid
   logic [rss_pkg::IDX_W-1:0]   sel_ff, sel_in;
   logic                        flag_ff, flag_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rss_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   rss_pkg::tbl_wr_type         tbl_wr;
   logic [AW-1:0]               rd_addr;
   logic [rss_pkg::FIT_W-1:0]   rd_data;
   logic [FR-1:0]               mul_a;
   logic [TW-1:0]               mul_b;
   logic [rss_pkg::PROD_W-1:0]  mul_p;

   logic                        req_fire;
   logic [NW-1:0]               n_cur;
   logic                        out_free;
   // shared running-sum adder and compare
   logic [TW-1:0]               addend;
   logic [TW-1:0]               run_sum;
   logic                        step_en;
   logic [NW-1:0]               step_idx;
   logic                        hit;
   logic                        last;

   rss_table #(.DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rss_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // active count: zero means one, capped at the table depth
   always_comb begin
      priority if (pop_ff == '0) begin
         n_cur = NW'(1);
      end else if (pop_ff > NW'(DEPTH)) begin
         n_cur = NW'(DEPTH);
      end else begin
         n_cur = pop_ff;
      end
   end

   // load beats go straight into the table; indexes past the table are dropped
   always_comb begin
      tbl_wr.en   = req_fire && (req_data.operation == rss_pkg::OP_LOAD)
                    && (32'(req_data.entry_index) < POP_MAX);
      tbl_wr.addr = req_data.entry_index;
      tbl_wr.data = req_data.fitness_value;
   end

   assign rd_addr = iss_ff[AW-1:0];

   // multiplier operands: n * (n + 1) for the rank total, else fraction * total
   always_comb begin
      if (state_ff == S_RTOT) begin
         mul_a = FR'(n_ff);
         mul_b = TW'(n_ff) + TW'(1);
      end else begin
         mul_a = rnd_ff;
         mul_b = tot_ff;
      end
   end

   // rank adds weight n - i, roulette adds the entry read back
   always_comb begin
      if (rank_ff && (state_ff == S_WALK)) begin
         addend   = TW'(n_ff - iss_ff);
         step_en  = 1'b1;
         step_idx = iss_ff;
      end else begin
         addend   = TW'(rd_data);
         step_en  = vld_ff;
         step_idx = pidx_ff;
      end
      run_sum = run_ff + addend;
      hit     = run_sum > thr_ff;
      last    = (step_idx == n_ff - NW'(1));
   end

   always_comb begin
      state_in     = state_ff;
      pop_in       = pop_ff;
      n_in         = n_ff;
      rank_in      = rank_ff;
      rnd_in       = rnd_ff;
      tot_in       = tot_ff;
      thr_in       = thr_ff;
      run_in       = run_ff;
      iss_in       = iss_ff;
      pidx_in      = pidx_ff;
      vld_in       = 1'b0;
      sel_in       = sel_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         pop_in = csr_data;
      end

      // output register: release on take, load from the finish state
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               n_in    = n_cur;
               rnd_in  = req_data.random_fraction;
               run_in  = '0;
               iss_in  = '0;
               flag_in = 1'b0;
               if (req_data.operation == rss_pkg::OP_ROULETTE) begin
                  rank_in  = 1'b0;
                  state_in = S_SUM;
               end else if (req_data.operation == rss_pkg::OP_RANK) begin
                  rank_in  = 1'b1;
                  state_in = S_RTOT;
               end
            end
         end
         S_SUM: begin
            if (iss_ff < n_ff) begin
               iss_in  = iss_ff + NW'(1);
               pidx_in = iss_ff;
               vld_in  = 1'b1;
            end
            if (step_en) begin
               run_in = run_sum;
               if (last) begin
                  tot_in   = run_sum;
                  vld_in   = 1'b0;
                  state_in = S_MUL;
               end
            end
         end
         S_RTOT: begin
            state_in = S_RHALF;
         end
         S_RHALF: begin
            tot_in   = mul_p[TW:1];
            state_in = S_MUL;
         end
         S_MUL: begin
            if (tot_ff == '0) begin
               sel_in   = '0;
               flag_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_THR;
            end
         end
         S_THR: begin
            // running sum must exceed floor(fraction * total / 2^frac)
            thr_in   = mul_p[FR+TW-1:FR];
            run_in   = '0;
            iss_in   = '0;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (rank_ff) begin
               iss_in = iss_ff + NW'(1);
            end else if (iss_ff < n_ff) begin
               iss_in  = iss_ff + NW'(1);
               pidx_in = iss_ff;
               vld_in  = 1'b1;
            end
            if (step_en) begin
               run_in = run_sum;
               // a walk that never exceeds ends on n-1 anyway
               if (hit || last) begin
                  sel_in   = step_idx[rss_pkg::IDX_W-1:0];
                  vld_in   = 1'b0;
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.selected_index = sel_ff;
               rsp_data_in.no_fitness     = flag_ff;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pop_ff       <= NW'(256);
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pop_ff       <= pop_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      rank_ff     <= rank_in;
      rnd_ff      <= rnd_in;
      tot_ff      <= tot_in;
      thr_ff      <= thr_in;
      run_ff      <= run_in;
      iss_ff      <= iss_in;
      pidx_ff     <= pidx_in;
      sel_ff      <= sel_in;
      flag_ff     <= flag_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
